/* sv/esp_trailer_length_calc_macros.svh */
// Assertion macros shared by the ESP trailer length calculator RTL.
`ifndef ESP_TRAILER_LENGTH_CALC_MACROS_SVH
`define ESP_TRAILER_LENGTH_CALC_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ETLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("etlc assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define ETLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("etlc assertion failed (next cycle)");

`else

`define ETLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ETLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/etlc_pkg.sv */
// Types, constants and size tables for the ESP trailer length calculator.
`default_nettype none

package etlc_pkg;

    localparam int ESP_HEADER_BYTES  = 8;
    localparam int ESP_TRAILER_BYTES = 2;

    localparam int PAYLOAD_W = 16;
    localparam int TFC_W     = 8;
    localparam int MODE_W    = 2;
    localparam int CIPHER_W  = 4;
    localparam int AUTH_W    = 4;
    localparam int PAD_W     = 8;
    localparam int LEN_W     = 17;
    localparam int IV_W      = 5;
    localparam int ICV_W     = 6;
    localparam int ERR_W     = 2;
    localparam int MASK_W    = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE      = 2'd0,
        MODE_INTEGRITY = 2'd1,
        MODE_CONFIDENT = 2'd2,
        MODE_COMBINED  = 2'd3
    } esp_mode_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK           = 2'd0,
        ERR_MODE_NONE    = 2'd1,
        ERR_ICV_MISSING  = 2'd2,
        ERR_PAD_OVERFLOW = 2'd3
    } err_code_t;

    localparam logic [CIPHER_W-1:0] CIPH_NONE   = 4'd0;
    localparam logic [CIPHER_W-1:0] CIPH_DES    = 4'd1;
    localparam logic [CIPHER_W-1:0] CIPH_3DES   = 4'd2;
    localparam logic [CIPHER_W-1:0] CIPH_AES_LO = 4'd3;
    localparam logic [CIPHER_W-1:0] CIPH_AES_HI = 4'd5;
    localparam logic [CIPHER_W-1:0] CIPH_CCM8_0 = 4'd6;
    localparam logic [CIPHER_W-1:0] CIPH_CCM8_1 = 4'd7;
    localparam logic [CIPHER_W-1:0] CIPH_CCM8_2 = 4'd8;
    localparam logic [CIPHER_W-1:0] CIPH_AES_M  = 4'd4;
    localparam logic [CIPHER_W-1:0] CIPH_CHACHA = 4'd15;

    localparam logic [AUTH_W-1:0] AUTH_MD5_96  = 4'd1;
    localparam logic [AUTH_W-1:0] AUTH_SHA1    = 4'd2;
    localparam logic [AUTH_W-1:0] AUTH_GMAC_0  = 4'd3;
    localparam logic [AUTH_W-1:0] AUTH_GMAC_1  = 4'd4;
    localparam logic [AUTH_W-1:0] AUTH_GMAC_2  = 4'd5;
    localparam logic [AUTH_W-1:0] AUTH_SHA256  = 4'd6;
    localparam logic [AUTH_W-1:0] AUTH_SHA384  = 4'd7;
    localparam logic [AUTH_W-1:0] AUTH_SHA512  = 4'd8;

    // Sizes for one item, handed from the lookup to the length arithmetic.
    typedef struct packed {
        logic [MASK_W-1:0] round_mask;
        logic [IV_W-1:0]   iv_bytes;
        logic [ICV_W-1:0]  icv_bytes;
        err_code_t         err;
    } etlc_sizes_t;

    // Rounding to the block size and then to 4 bytes is rounding to the larger of the two.
    function automatic logic [MASK_W-1:0] round_mask_of(input logic [CIPHER_W-1:0] cipher);
        logic [MASK_W-1:0] m;
        case (cipher) inside
            CIPH_NONE, CIPH_CHACHA: m = 4'd3;
            CIPH_DES, CIPH_3DES:    m = 4'd7;
            default:                m = 4'd15;
        endcase
        return m;
    endfunction

    function automatic logic [IV_W-1:0] cipher_iv_of(input logic [CIPHER_W-1:0] cipher);
        logic [IV_W-1:0] v;
        case (cipher) inside
            CIPH_NONE:                        v = 5'd0;
            CIPH_AES_LO, CIPH_AES_M, CIPH_AES_HI: v = 5'd16;
            default:                          v = 5'd8;
        endcase
        return v;
    endfunction

    function automatic logic [ICV_W-1:0] cipher_icv_of(input logic [CIPHER_W-1:0] cipher);
        logic [ICV_W-1:0] v;
        case (cipher) inside
            CIPH_CCM8_0, CIPH_CCM8_1, CIPH_CCM8_2: v = 6'd8;
            [4'd9:CIPH_CHACHA]:                    v = 6'd16;
            default:                               v = 6'd0;
        endcase
        return v;
    endfunction

    // Unknown auth codes act as auth none.
    function automatic logic [ICV_W-1:0] auth_icv_of(input logic [AUTH_W-1:0] auth);
        logic [ICV_W-1:0] v;
        case (auth) inside
            AUTH_MD5_96:                                       v = 6'd12;
            AUTH_SHA1:                                         v = 6'd20;
            AUTH_GMAC_0, AUTH_GMAC_1, AUTH_GMAC_2, AUTH_SHA256: v = 6'd16;
            AUTH_SHA384:                                       v = 6'd24;
            AUTH_SHA512:                                       v = 6'd32;
            default:                                           v = 6'd0;
        endcase
        return v;
    endfunction

    function automatic logic [IV_W-1:0] auth_iv_of(input logic [AUTH_W-1:0] auth);
        logic [IV_W-1:0] v;
        case (auth) inside
            AUTH_GMAC_0, AUTH_GMAC_1, AUTH_GMAC_2: v = 5'd8;
            default:                               v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* sv/etlc_lookup.sv */
// Mode, cipher and auth decode into round mask, IV size, ICV size and base error.
`default_nettype none

module etlc_lookup (
    input  wire logic [etlc_pkg::MODE_W-1:0]   esp_mode,
    input  wire logic [etlc_pkg::CIPHER_W-1:0] cipher_alg,
    input  wire logic [etlc_pkg::AUTH_W-1:0]   auth_alg,
    output etlc_pkg::etlc_sizes_t              sizes
);
    import etlc_pkg::*;

    logic [ICV_W-1:0] auth_icv;
    logic [ICV_W-1:0] comb_icv;

    assign auth_icv = auth_icv_of(auth_alg);
    assign comb_icv = (auth_icv != '0) ? auth_icv : cipher_icv_of(cipher_alg);

    always_comb
    begin
        sizes.round_mask = round_mask_of(cipher_alg);
        sizes.iv_bytes   = '0;
        sizes.icv_bytes  = '0;
        sizes.err        = ERR_OK;
        unique case (esp_mode_t'(esp_mode))
            MODE_NONE:
            begin
                sizes.err = ERR_MODE_NONE;
            end
            MODE_INTEGRITY:
            begin
                sizes.iv_bytes  = auth_iv_of(auth_alg);
                sizes.icv_bytes = auth_icv;
                if (auth_icv == '0)
                    sizes.err = ERR_ICV_MISSING;
            end
            MODE_CONFIDENT:
            begin
                sizes.iv_bytes = cipher_iv_of(cipher_alg);
            end
            MODE_COMBINED:
            begin
                sizes.iv_bytes  = cipher_iv_of(cipher_alg);
                sizes.icv_bytes = comb_icv;
                if (comb_icv == '0)
                    sizes.err = ERR_ICV_MISSING;
            end
            default:
            begin
                sizes.err = ERR_MODE_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/etlc_pad.sv */
// Padding, padded length, total length and final error code for one item.
`default_nettype none

module etlc_pad (
    input  wire logic [etlc_pkg::PAYLOAD_W-1:0] payload_length,
    input  wire logic [etlc_pkg::TFC_W-1:0]     tfc_pad_length,
    input  wire etlc_pkg::etlc_sizes_t          sizes,
    output logic [etlc_pkg::PAD_W-1:0]          pad_length,
    output logic [etlc_pkg::LEN_W-1:0]          padded_length,
    output logic [etlc_pkg::LEN_W-1:0]          total_length,
    output logic [etlc_pkg::ERR_W-1:0]          error_code
);
    import etlc_pkg::*;

    logic [LEN_W-1:0] paddable;
    logic [LEN_W-1:0] mask;
    logic [LEN_W-1:0] padded;
    logic [LEN_W-1:0] pad;
    logic             pad_over;

    assign paddable = LEN_W'(payload_length) + LEN_W'(tfc_pad_length)
                    + LEN_W'(ESP_TRAILER_BYTES);
    assign mask     = LEN_W'(sizes.round_mask);
    assign padded   = (paddable + mask) & ~mask;
    assign pad      = padded - paddable;
    assign pad_over = |pad[LEN_W-1:PAD_W];

    assign pad_length    = pad[PAD_W-1:0];
    assign padded_length = padded;
    assign total_length  = LEN_W'(ESP_HEADER_BYTES) + LEN_W'(sizes.iv_bytes) + padded
                         + LEN_W'(sizes.icv_bytes);

    // Earlier errors win over pad overflow.
    always_comb
    begin
        if (sizes.err == ERR_OK && pad_over)
            error_code = ERR_PAD_OVERFLOW;
        else
            error_code = sizes.err;
    end

endmodule

`default_nettype wire

/* sv/esp_trailer_length_calc.sv */
// Top level of the ESP trailer length calculator: input register, lookup, arithmetic, result register.
//
//   channel   handshake          payload
//   -------   ----------------   ---------------------------------------------------
//   request   start / busy       payload_length tfc_pad_length esp_mode cipher_alg
//                                auth_alg
//   result    done (strobe)      pad_length padded_length iv_bytes icv_bytes
//                                total_length error_code
//
// One item per cycle. An item is captured in the input registers, and done rises
// when its result is loaded into the result registers; the path between the input and
// result registers is one table lookup followed by a 17-bit add/mask and a
// four-term add.
// busy never rises: the pipeline has no stall, and results are not held.
// Reset clears both valid flags; payload registers are not reset.
`default_nettype none
`include "esp_trailer_length_calc_macros.svh"

module esp_trailer_length_calc (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [etlc_pkg::PAYLOAD_W-1:0] payload_length,
    input  wire logic [etlc_pkg::TFC_W-1:0]     tfc_pad_length,
    input  wire logic [etlc_pkg::MODE_W-1:0]    esp_mode,
    input  wire logic [etlc_pkg::CIPHER_W-1:0]  cipher_alg,
    input  wire logic [etlc_pkg::AUTH_W-1:0]    auth_alg,
    output logic                                done,
    output logic [etlc_pkg::PAD_W-1:0]          pad_length,
    output logic [etlc_pkg::LEN_W-1:0]          padded_length,
    output logic [etlc_pkg::IV_W-1:0]           iv_bytes,
    output logic [etlc_pkg::ICV_W-1:0]          icv_bytes,
    output logic [etlc_pkg::LEN_W-1:0]          total_length,
    output logic [etlc_pkg::ERR_W-1:0]          error_code
);
    import etlc_pkg::*;

    logic                 accept;
    logic                 in_valid_reg;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [TFC_W-1:0]     tfc_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [CIPHER_W-1:0]  cipher_reg;
    logic [AUTH_W-1:0]    auth_reg;

    etlc_sizes_t          sizes;
    logic [PAD_W-1:0]     pad_next;
    logic [LEN_W-1:0]     padded_next;
    logic [LEN_W-1:0]     total_next;
    logic [ERR_W-1:0]     err_next;

    logic                 out_valid_reg;
    logic [PAD_W-1:0]     pad_reg;
    logic [LEN_W-1:0]     padded_reg;
    logic [IV_W-1:0]      iv_reg;
    logic [ICV_W-1:0]     icv_reg;
    logic [LEN_W-1:0]     total_reg;
    logic [ERR_W-1:0]     err_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= accept;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            payload_reg <= payload_length;
            tfc_reg     <= tfc_pad_length;
            mode_reg    <= esp_mode;
            cipher_reg  <= cipher_alg;
            auth_reg    <= auth_alg;
        end
    end

    etlc_lookup u_lookup (
        .esp_mode   (mode_reg),
        .cipher_alg (cipher_reg),
        .auth_alg   (auth_reg),
        .sizes      (sizes)
    );

    etlc_pad u_pad (
        .payload_length (payload_reg),
        .tfc_pad_length (tfc_reg),
        .sizes          (sizes),
        .pad_length     (pad_next),
        .padded_length  (padded_next),
        .total_length   (total_next),
        .error_code     (err_next)
    );

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            pad_reg    <= pad_next;
            padded_reg <= padded_next;
            iv_reg     <= sizes.iv_bytes;
            icv_reg    <= sizes.icv_bytes;
            total_reg  <= total_next;
            err_reg    <= err_next;
        end
    end

    assign done          = out_valid_reg;
    assign pad_length    = pad_reg;
    assign padded_length = padded_reg;
    assign iv_bytes      = iv_reg;
    assign icv_bytes     = icv_reg;
    assign total_length  = total_reg;
    assign error_code    = err_reg;

    `ETLC_ASSERT_NXT(a_accept_loads, clk, rst_n, accept, in_valid_reg)
    `ETLC_ASSERT_NXT(a_stage_to_done, clk, rst_n, in_valid_reg, done)
    `ETLC_ASSERT_IMP(a_padded_aligned, clk, rst_n, done, padded_length[1:0] == 2'b00)
    `ETLC_ASSERT_IMP(a_mode_none_sizes, clk, rst_n, done && error_code == ERR_MODE_NONE, iv_bytes == '0 && icv_bytes == '0)
    `ETLC_ASSERT_IMP(a_total_sum, clk, rst_n, done, total_length == LEN_W'(ESP_HEADER_BYTES) + LEN_W'(iv_bytes) + padded_length + LEN_W'(icv_bytes))

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the ESP trailer length calculator: directed and random requests.
import etlc_pkg::*;

typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic [TFC_W-1:0]     tfc;
    esp_mode_t            mode;
    logic [CIPHER_W-1:0]  cipher;
    logic [AUTH_W-1:0]    auth;
} esp_request_t;

typedef struct packed {
    logic [PAD_W-1:0] pad;
    logic [LEN_W-1:0] padded;
    logic [IV_W-1:0]  iv;
    logic [ICV_W-1:0] icv;
    logic [LEN_W-1:0] total;
    err_code_t        err;
} esp_layout_t;

class layout_scoreboard;
    esp_layout_t pending_layouts[$];
    int          errors = 0;

    function esp_layout_t layout_of(esp_request_t r);
        int unsigned paddable, blk, padded, pad, iv, icv;
        int unsigned civ, cicv, aiv, aicv;
        esp_layout_t l;
        case (r.cipher)
            CIPH_NONE:                             begin blk = 1;  civ = 0;  cicv = 0;  end
            CIPH_DES, CIPH_3DES:                   begin blk = 8;  civ = 8;  cicv = 0;  end
            CIPH_AES_LO, CIPH_AES_M, CIPH_AES_HI:  begin blk = 16; civ = 16; cicv = 0;  end
            CIPH_CCM8_0, CIPH_CCM8_1, CIPH_CCM8_2: begin blk = 16; civ = 8;  cicv = 8;  end
            CIPH_CHACHA:                           begin blk = 4;  civ = 8;  cicv = 16; end
            // ccm16 and gcm
            default:                               begin blk = 16; civ = 8;  cicv = 16; end
        endcase
        case (r.auth)
            AUTH_MD5_96:                           begin aicv = 12; aiv = 0; end
            AUTH_SHA1:                             begin aicv = 20; aiv = 0; end
            AUTH_GMAC_0, AUTH_GMAC_1, AUTH_GMAC_2: begin aicv = 16; aiv = 8; end
            AUTH_SHA256:                           begin aicv = 16; aiv = 0; end
            AUTH_SHA384:                           begin aicv = 24; aiv = 0; end
            AUTH_SHA512:                           begin aicv = 32; aiv = 0; end
            // none and unknown codes
            default:                               begin aicv = 0;  aiv = 0; end
        endcase

        paddable = r.payload + r.tfc + ESP_TRAILER_BYTES;
        padded   = ((paddable + blk - 1) / blk) * blk;
        padded   = (padded + 3) & ~32'd3;
        pad      = padded - paddable;

        iv    = 0;
        icv   = 0;
        l.err = ERR_OK;
        case (r.mode)
            MODE_NONE: l.err = ERR_MODE_NONE;
            MODE_INTEGRITY:
            begin
                iv  = aiv;
                icv = aicv;
                if (icv == 0) l.err = ERR_ICV_MISSING;
            end
            MODE_CONFIDENT: iv = civ;
            default:
            begin
                iv  = civ;
                icv = (aicv != 0) ? aicv : cicv;
                if (icv == 0) l.err = ERR_ICV_MISSING;
            end
        endcase
        // unreachable with these block sizes, kept for completeness
        if (l.err == ERR_OK && pad > 255) l.err = ERR_PAD_OVERFLOW;

        l.pad    = pad[PAD_W-1:0];
        l.padded = padded[LEN_W-1:0];
        l.iv     = iv[IV_W-1:0];
        l.icv    = icv[ICV_W-1:0];
        l.total  = LEN_W'(ESP_HEADER_BYTES + iv + padded + icv);
        return l;
    endfunction

    function void note_request(esp_request_t r);
        pending_layouts.push_back(layout_of(r));
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    function void check_layout(esp_layout_t got);
        esp_layout_t want;
        if (pending_layouts.size() == 0)
        begin
            $display("%0t: result with no request pending, actual %p", $time, got);
            errors++;
            return;
        end
        want = pending_layouts.pop_front();
        compare_field("pad_length",    want.pad,    got.pad);
        compare_field("padded_length", want.padded, got.padded);
        compare_field("iv_bytes",      want.iv,     got.iv);
        compare_field("icv_bytes",     want.icv,    got.icv);
        compare_field("total_length",  want.total,  got.total);
        compare_field("error_code",    want.err,    got.err);
    endfunction
endclass

module testbench;

    localparam logic [AUTH_W-1:0] AUTH_NONE    = 4'd0;
    localparam logic [AUTH_W-1:0] AUTH_UNKNOWN = 4'd15;
    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_LIMIT  = 200;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    esp_request_t         req = '0;
    logic                 busy;
    logic                 done;
    logic [PAD_W-1:0]     pad_length;
    logic [LEN_W-1:0]     padded_length;
    logic [IV_W-1:0]      iv_bytes;
    logic [ICV_W-1:0]     icv_bytes;
    logic [LEN_W-1:0]     total_length;
    logic [ERR_W-1:0]     error_code;

    layout_scoreboard sb = new();

    esp_trailer_length_calc i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .payload_length (req.payload),
        .tfc_pad_length (req.tfc),
        .esp_mode       (req.mode),
        .cipher_alg     (req.cipher),
        .auth_alg       (req.auth),
        .done           (done),
        .pad_length     (pad_length),
        .padded_length  (padded_length),
        .iv_bytes       (iv_bytes),
        .icv_bytes      (icv_bytes),
        .total_length   (total_length),
        .error_code     (error_code)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        esp_layout_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got.pad    = pad_length;
                got.padded = padded_length;
                got.iv     = iv_bytes;
                got.icv    = icv_bytes;
                got.total  = total_length;
                got.err    = err_code_t'(error_code);
                sb.check_layout(got);
            end
            if (start && !busy) sb.note_request(req);
        end
    end

    function automatic esp_request_t make_request(int unsigned payload, int unsigned tfc,
                                                   esp_mode_t mode, logic [CIPHER_W-1:0] cipher,
                                                   logic [AUTH_W-1:0] auth);
        esp_request_t r;
        r.payload = payload[PAYLOAD_W-1:0];
        r.tfc     = tfc[TFC_W-1:0];
        r.mode    = mode;
        r.cipher  = cipher;
        r.auth    = auth;
        return r;
    endfunction

    function automatic esp_request_t random_request();
        esp_request_t r;
        case ($urandom_range(0, 3))
            0: r.payload = 16'($urandom_range(0, 64));
            1: r.payload = 16'($urandom);
            2: r.payload = 16'(65535 - $urandom_range(0, 300));
            default: r.payload = 16'($urandom_range(40, 9000));
        endcase
        case ($urandom_range(0, 3))
            0: r.tfc = '0;
            1: r.tfc = '1;
            default: r.tfc = 8'($urandom);
        endcase
        r.mode   = esp_mode_t'($urandom_range(0, 3));
        r.cipher = 4'($urandom_range(0, 15));
        // mostly known auth codes, some unknown ones
        r.auth   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 8));
        return r;
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic drive_request(esp_request_t r);
        @(negedge clk);
        req   <= r;
        start <= 1'b1;
        do @(posedge clk); while (busy);
    endtask

    // Drop start, with noise on the data ports.
    task automatic pause_requests(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
            req   <= random_request();
        end
    endtask

    task automatic wait_drained();
        int cycles;
        cycles = 0;
        while (sb.pending_layouts.size() != 0 && cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        if (sb.pending_layouts.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.pending_layouts.size());
            sb.errors++;
            sb.pending_layouts.delete();
        end
    endtask

    initial
    begin
        int items;
        int burst;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        pause_requests(2);

        // directed: extremes, error cases, mode and cipher mismatches
        drive_request(make_request(0, 0, MODE_NONE, CIPH_NONE, AUTH_NONE));
        drive_request(make_request(65535, 255, MODE_COMBINED, CIPH_CHACHA, AUTH_SHA512));
        drive_request(make_request(65535, 0, MODE_CONFIDENT, CIPH_AES_HI, AUTH_NONE));
        drive_request(make_request(0, 255, MODE_INTEGRITY, CIPH_NONE, AUTH_NONE));
        drive_request(make_request(100, 0, MODE_COMBINED, CIPH_NONE, AUTH_NONE));
        drive_request(make_request(37, 3, MODE_COMBINED, CIPH_AES_LO, AUTH_UNKNOWN));
        drive_request(make_request(37, 3, MODE_INTEGRITY, CIPH_DES, AUTH_GMAC_1));
        drive_request(make_request(1500, 0, MODE_CONFIDENT, CIPH_NONE, AUTH_SHA1));
        // sweep every cipher and auth code, cycling through the modes
        for (int i = 0; i < 16; i++)
            drive_request(make_request(i * 98, i * 17, esp_mode_t'(i % 4), 4'(i), 4'(15 - i)));

        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && items < RANDOM_ITEMS; b++)
            begin
                drive_request(random_request());
                items++;
                if (items == RANDOM_ITEMS / 2)
                begin
                    pause_requests(1);
                    wait_drained();
                end
            end
            if ($urandom_range(0, 3) != 0) pause_requests($urandom_range(1, 6));
        end
        pause_requests(1);

        wait_drained();
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("testbench failed");
        $finish;
    end

endmodule
